// ----- design/deadline_min_heap_defines.svh -----
// Assertion macros shared by the checker of the deadline heap.
`ifndef DEADLINE_MIN_HEAP_DEFINES_SVH
`define DEADLINE_MIN_HEAP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DMH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deadline_min_heap check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define DMH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deadline_min_heap check failed");

`endif

// ----- design/dmh_pkg.sv -----
// Package with the types and constants of the deadline heap.
package dmh_pkg;
	localparam int BKT_DEPTH = 1024;
	localparam int BKT_W = $clog2(BKT_DEPTH);
	localparam int CNT_W = BKT_W + 1;
	localparam int DL_W = 64;
	localparam int ACT_W = 11;

	localparam logic CFG_TIME_LIMIT = 1'b0;
	localparam logic CFG_ACTIVE = 1'b1;
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_REMOVE = 1'b1;
	localparam logic STATUS_VALID = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_CHK, ST_CHK2, ST_RM_SLOT, ST_RM_MOV, ST_RM_MDL,
		ST_UP_RD, ST_UP_FT, ST_UP_CMP, ST_DN, ST_DN_FTL, ST_DN_CMPL,
		ST_DN_FTR, ST_DN_CMPR, ST_DN_DEC, ST_PLACE, ST_REP, ST_REP_FT, ST_REP_OUT
	} state_t;

	typedef enum logic [2:0] {
		HA_PARENT, HA_LAST, HA_LEFT, HA_RIGHT, HA_TOP
	} ho_sel_t;

	typedef struct packed {
		logic ld_in;
		logic reg_rd;
		logic ho_rd;
		ho_sel_t ho_sel;
		logic ft_rd;
		logic add_commit;
		logic rm_commit;
		logic rm_slot;
		logic cur_from_ho;
		logic cur_dl_ld;
		logic up_move;
		logic dn_move;
		logic best_init;
		logic best_try;
		logic place;
		logic clr_step;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic is_remove;
		logic reg_hit;
		logic full;
		logic empty;
		logic pos_zero;
		logic slot_last;
		logic up_stop;
		logic left_ok;
		logic right_ok;
		logic best_is_pos;
		logic clr_last;
		logic out_free;
	} stat_t;
endpackage

// ----- design/dmh_ctrl.sv -----
// Controller state machine that sequences heap updates and reports.
module dmh_ctrl import dmh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);
	state_t state_q, state_d;
	logic first_q, first_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
		end
	end

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		cmd = '0;
		cmd.ho_sel = HA_TOP;
		in_ready = 1'b0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (st.in_range) begin
					cmd.reg_rd = 1'b1;
					state_d = ST_CHK2;
				end else begin
					state_d = ST_REP;
				end
			end
			ST_CHK2: begin
				first_d = 1'b1;
				if (!st.is_remove) begin
					if (st.reg_hit || st.full) begin
						state_d = ST_REP;
					end else begin
						cmd.add_commit = 1'b1;
						state_d = ST_UP_RD;
					end
				end else begin
					if (!st.reg_hit || st.empty) begin
						state_d = ST_REP;
					end else begin
						cmd.rm_commit = 1'b1;
						state_d = ST_RM_SLOT;
					end
				end
			end
			ST_RM_SLOT: begin
				cmd.rm_slot = 1'b1;
				if (st.slot_last) begin
					state_d = ST_REP;
				end else begin
					cmd.ho_rd = 1'b1;
					cmd.ho_sel = HA_LAST;
					state_d = ST_RM_MOV;
				end
			end
			ST_RM_MOV: begin
				cmd.cur_from_ho = 1'b1;
				cmd.ft_rd = 1'b1;
				state_d = ST_RM_MDL;
			end
			ST_RM_MDL: begin
				cmd.cur_dl_ld = 1'b1;
				state_d = ST_UP_RD;
			end
			ST_UP_RD: begin
				if (st.pos_zero) begin
					state_d = (first_q && st.is_remove) ? ST_DN : ST_PLACE;
				end else begin
					cmd.ho_rd = 1'b1;
					cmd.ho_sel = HA_PARENT;
					state_d = ST_UP_FT;
				end
			end
			ST_UP_FT: begin
				cmd.ft_rd = 1'b1;
				state_d = ST_UP_CMP;
			end
			ST_UP_CMP: begin
				if (st.up_stop) begin
					state_d = (first_q && st.is_remove) ? ST_DN : ST_PLACE;
				end else begin
					cmd.up_move = 1'b1;
					first_d = 1'b0;
					state_d = ST_UP_RD;
				end
			end
			ST_DN: begin
				if (st.left_ok) begin
					cmd.ho_rd = 1'b1;
					cmd.ho_sel = HA_LEFT;
					state_d = ST_DN_FTL;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_DN_FTL: begin
				cmd.ft_rd = 1'b1;
				state_d = ST_DN_CMPL;
			end
			ST_DN_CMPL: begin
				cmd.best_init = 1'b1;
				if (st.right_ok) begin
					cmd.ho_rd = 1'b1;
					cmd.ho_sel = HA_RIGHT;
					state_d = ST_DN_FTR;
				end else begin
					state_d = ST_DN_DEC;
				end
			end
			ST_DN_FTR: begin
				cmd.ft_rd = 1'b1;
				state_d = ST_DN_CMPR;
			end
			ST_DN_CMPR: begin
				cmd.best_try = 1'b1;
				state_d = ST_DN_DEC;
			end
			ST_DN_DEC: begin
				if (st.best_is_pos) begin
					state_d = ST_PLACE;
				end else begin
					cmd.dn_move = 1'b1;
					state_d = ST_DN;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d = ST_REP;
			end
			ST_REP: begin
				if (st.empty) begin
					if (st.out_free) begin
						cmd.out_ld = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.ho_rd = 1'b1;
					cmd.ho_sel = HA_TOP;
					state_d = ST_REP_FT;
				end
			end
			ST_REP_FT: begin
				cmd.ft_rd = 1'b1;
				state_d = ST_REP_OUT;
			end
			ST_REP_OUT: begin
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ----- design/dmh_datapath.sv -----
// Datapath with the heap memories, the sift registers and the result register.
module dmh_datapath import dmh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            st,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [DL_W-1:0]  cfg_data,
	input  logic             operation,
	input  logic [BKT_W-1:0] bkt_num,
	input  logic [DL_W-1:0]  flush_time,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             status,
	output logic [BKT_W-1:0] top_bucket,
	output logic [DL_W-1:0]  top_deadline
);
	logic [BKT_W-1:0] ho_mem [BKT_DEPTH];
	logic [BKT_W-1:0] bp_mem [BKT_DEPTH];
	logic [DL_W-1:0]  ft_mem [BKT_DEPTH];
	logic             reg_mem [BKT_DEPTH];

	logic [DL_W-1:0]  limit_q;
	logic [ACT_W-1:0] active_q;
	logic             op_q;
	logic [BKT_W-1:0] b_q;
	logic [DL_W-1:0]  ft_q;
	logic [BKT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BKT_W-1:0] cur_b_q;
	logic [DL_W-1:0]  cur_dl_q;
	logic [BKT_W-1:0] best_q;
	logic [BKT_W-1:0] best_b_q;
	logic [DL_W-1:0]  best_dl_q;
	logic [CNT_W-1:0] clr_q;
	logic [BKT_W-1:0] ho_rd_q;
	logic [BKT_W-1:0] bp_rd_q;
	logic [DL_W-1:0]  ft_rd_q;
	logic             reg_rd_q;
	logic             out_valid_q;
	logic             status_q;
	logic [BKT_W-1:0] top_bucket_q;
	logic [DL_W-1:0]  top_deadline_q;

	logic [BKT_W-1:0] parent;
	logic [BKT_W+1:0] left_w;
	logic [BKT_W+1:0] right_w;
	logic [BKT_W-1:0] ho_ra;
	logic [DL_W-1:0]  dl;
	logic             ho_we;
	logic [BKT_W-1:0] ho_wd;
	logic             reg_we;
	logic [BKT_W-1:0] reg_wa;
	logic             reg_wd;
	logic [CNT_W-1:0] last;

	assign parent = BKT_W'((pos_q - BKT_W'(1)) >> 1);
	assign left_w = {1'b0, pos_q, 1'b1};
	assign right_w = left_w + (BKT_W+2)'(1);
	assign last = cnt_q - CNT_W'(1);
	assign dl = ft_rd_q + limit_q;

	always_comb begin
		case (cmd.ho_sel)
			HA_PARENT: ho_ra = parent;
			HA_LAST:   ho_ra = last[BKT_W-1:0];
			HA_LEFT:   ho_ra = left_w[BKT_W-1:0];
			HA_RIGHT:  ho_ra = right_w[BKT_W-1:0];
			default:   ho_ra = '0;
		endcase
	end

	assign ho_we = cmd.up_move | cmd.dn_move | cmd.place;
	assign ho_wd = cmd.up_move ? ho_rd_q : (cmd.dn_move ? best_b_q : cur_b_q);
	assign reg_we = cmd.clr_step | cmd.add_commit | cmd.rm_commit;
	assign reg_wa = cmd.clr_step ? clr_q[BKT_W-1:0] : b_q;
	assign reg_wd = cmd.add_commit;

	always_ff @(posedge clk) begin
		if (ho_we) ho_mem[pos_q] <= ho_wd;
		if (cmd.ho_rd) ho_rd_q <= ho_mem[ho_ra];
	end

	always_ff @(posedge clk) begin
		if (ho_we) bp_mem[ho_wd] <= pos_q;
		if (cmd.rm_commit) bp_rd_q <= bp_mem[b_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_commit) ft_mem[b_q] <= ft_q;
		if (cmd.ft_rd) ft_rd_q <= ft_mem[ho_rd_q];
	end

	always_ff @(posedge clk) begin
		if (reg_we) reg_mem[reg_wa] <= reg_wd;
		if (cmd.reg_rd) reg_rd_q <= reg_mem[b_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			active_q <= ACT_W'(BKT_DEPTH);
			cnt_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == CFG_TIME_LIMIT) limit_q <= cfg_data;
			if (cfg_write && cfg_index == CFG_ACTIVE) active_q <= cfg_data[ACT_W-1:0];
			if (cmd.clr_step) clr_q <= clr_q + CNT_W'(1);
			if (cmd.add_commit) cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.rm_slot) cnt_q <= last;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q <= operation;
			b_q <= bkt_num;
			ft_q <= flush_time;
		end
		if (cmd.add_commit) begin
			pos_q <= cnt_q[BKT_W-1:0];
			cur_b_q <= b_q;
			cur_dl_q <= ft_q + limit_q;
		end else if (cmd.rm_slot) begin
			pos_q <= bp_rd_q;
		end else if (cmd.up_move) begin
			pos_q <= parent;
		end else if (cmd.dn_move) begin
			pos_q <= best_q;
		end
		if (cmd.cur_from_ho) cur_b_q <= ho_rd_q;
		if (cmd.cur_dl_ld) cur_dl_q <= dl;
		if (cmd.best_init) begin
			if (dl < cur_dl_q) begin
				best_q <= left_w[BKT_W-1:0];
				best_b_q <= ho_rd_q;
				best_dl_q <= dl;
			end else begin
				best_q <= pos_q;
				best_b_q <= cur_b_q;
				best_dl_q <= cur_dl_q;
			end
		end else if (cmd.best_try && dl < best_dl_q) begin
			best_q <= right_w[BKT_W-1:0];
			best_b_q <= ho_rd_q;
			best_dl_q <= dl;
		end
		if (cmd.out_ld) begin
			if (cnt_q == '0) begin
				status_q <= STATUS_EMPTY;
				top_bucket_q <= '0;
				top_deadline_q <= '0;
			end else begin
				status_q <= STATUS_VALID;
				top_bucket_q <= ho_rd_q;
				top_deadline_q <= dl;
			end
		end
	end

	assign st.in_range = {1'b0, b_q} < active_q;
	assign st.is_remove = (op_q == OP_REMOVE);
	assign st.reg_hit = reg_rd_q;
	assign st.full = (cnt_q == CNT_W'(BKT_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign st.pos_zero = (pos_q == '0);
	assign st.slot_last = ({1'b0, bp_rd_q} == last);
	assign st.up_stop = (dl <= cur_dl_q);
	assign st.left_ok = left_w < {1'b0, cnt_q};
	assign st.right_ok = right_w < {1'b0, cnt_q};
	assign st.best_is_pos = (best_q == pos_q);
	assign st.clr_last = (clr_q[BKT_W-1:0] == BKT_W'(BKT_DEPTH - 1));
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign top_bucket = top_bucket_q;
	assign top_deadline = top_deadline_q;
endmodule

// ----- design/deadline_min_heap.sv -----
// Top level of the deadline heap: controller and datapath.
// Indexed binary min-heap of bucket numbers ordered by flush time plus time limit.
// Input channel (in_valid/in_ready): operation (add or remove), bkt_num and
// flush_time. Each accepted item yields exactly one result item on the output
// channel (out_valid/out_ready): status, top_bucket and top_deadline.
// Configuration is a plain write port: cfg_write, cfg_index (0 time limit,
// 1 active bucket count) and cfg_data, taken on any edge with cfg_write high.
// Items are handled one at a time; in_ready is high only while the block is idle.
// An out-of-range item goes from the range check straight to the report of the
// heap top, and an item ignored for another reason goes there after its
// registration bit is read. An add climbs from the end of the heap, reading and
// comparing the parent at each level. A remove moves the last entry into the
// freed slot, then sifts it up, or down when it does not climb at all. The block
// is back in idle in the cycle after the result is loaded. The time per item is
// set by the single read port of each heap memory, read once per node compared.
// After reset the registration bits are cleared by a pass over every bucket,
// during which in_ready stays low.
// The result sits in an output register; the block accepts the next item while
// it waits, but holds the following result until the receiver takes it.
module deadline_min_heap import dmh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [DL_W-1:0]  cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	input  logic [BKT_W-1:0] bkt_num,
	input  logic [DL_W-1:0]  flush_time,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             status,
	output logic [BKT_W-1:0] top_bucket,
	output logic [DL_W-1:0]  top_deadline
);
	cmd_t  cmd;
	stat_t st;

	dmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	dmh_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.bkt_num      (bkt_num),
		.flush_time   (flush_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.top_bucket   (top_bucket),
		.top_deadline (top_deadline)
	);
endmodule

// ----- design/dmh_checker.sv -----
// Port-level checker for the deadline heap and its bind statement.
`include "deadline_min_heap_defines.svh"
module dmh_port_props import dmh_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             status,
	input logic [BKT_W-1:0] top_bucket,
	input logic [DL_W-1:0]  top_deadline
);
	logic                    top_zero;
	logic [DL_W+BKT_W:0]     res_item;

	assign top_zero = (top_bucket == '0) && (top_deadline == '0);
	assign res_item = {status, top_bucket, top_deadline};

	`DMH_ASSERT_NOW(a_empty_zero, out_valid && status == STATUS_EMPTY, top_zero)
	`DMH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`DMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_item))
endmodule

bind deadline_min_heap dmh_port_props u_dmh_port_props (.*);
